FILE: rtl/cadd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadd_pkg
// Shared types and constants for the copy/add delta decoder.
// ----------------------------------------------------------------------------
package cadd_pkg;

  localparam int REF_DEPTH     = 4096;
  localparam int MAX_COPY      = 64;
  localparam int LEN_BITS      = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam int ADDR_BITS     = $clog2(REF_DEPTH);
  localparam int OFF_BITS      = $clog2(REF_DEPTH + 1);
  localparam int CFG_BITS      = 13;
  localparam int COPY_LEN_BITS = $clog2(MAX_COPY + 1);
  localparam int LEN_WIDE      = LEN_BITS + 4;
  localparam int OFF_WIDE      = OFF_BITS + 4;
  localparam int SUM_BITS      = ((CFG_BITS > OFF_BITS) ? CFG_BITS : OFF_BITS) + 1;
  localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_DELTA = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  localparam logic [7:0] CHR_ADD     = 8'h41;
  localparam logic [7:0] CHR_COPY    = 8'h43;
  localparam logic [7:0] CHR_COLON   = 8'h3A;
  localparam logic [7:0] CHR_COMMA   = 8'h2C;
  localparam logic [7:0] CHR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHR_ZERO    = 8'h30;
  localparam logic [7:0] CHR_NINE    = 8'h39;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_ADD_LEN,
    PH_ADD_DATA,
    PH_COPY_LEN,
    PH_COPY_OFF
  } phase_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EMIT,
    CMD_COPY
  } cmd_kind_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_COPY
  } back_state_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [ADDR_BITS-1:0]     addr;
    logic [7:0]               data;
    logic                     valid;
    logic [1:0]               status;
    logic [COPY_LEN_BITS-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } front_ctl_t;

endpackage

FILE: rtl/cadd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadd_queue
// Short request queue between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module cadd_queue import cadd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  front_ctl_t push_ctl,
  input  cmd_t       push_cmd,
  output logic       full,
  input  logic       pop,
  output cmd_t       pop_cmd,
  output logic       empty
);

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push_ctl.push && !push_ctl.full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/cadd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadd_front
// Delta parser: accepts items, tracks the command syntax and queues requests.
// ----------------------------------------------------------------------------
module cadd_front import cadd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_BITS-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [ADDR_BITS-1:0] ref_addr,
  input  logic [7:0]           data_byte,
  output front_ctl_t           ctl,
  input  logic                 q_full,
  output cmd_t                 cmd
);

  typedef struct packed {
    phase_t phase;
    logic   nl;
    logic   err;
    logic   fresh;
  } begin_t;

  phase_t               phase;
  phase_t               phase_next;
  logic [LEN_BITS-1:0]  len_acc;
  logic [LEN_BITS-1:0]  len_next;
  logic [OFF_BITS-1:0]  off_acc;
  logic [OFF_BITS-1:0]  off_next;
  logic                 seen;
  logic                 seen_next;
  logic [LEN_BITS-1:0]  add_rem;
  logic [LEN_BITS-1:0]  add_rem_next;
  logic                 nl;
  logic                 nl_next;
  logic                 err;
  logic                 err_next;
  logic [CFG_BITS-1:0]  ref_length;

  logic                 accept;
  logic                 is_digit;
  logic [LEN_WIDE-1:0]  len_val;
  logic [OFF_WIDE-1:0]  off_val;
  logic [SUM_BITS-1:0]  used;
  logic [SUM_BITS-1:0]  copy_end;
  logic                 copy_bad;
  logic                 copy_go;
  logic                 emit_add;
  logic                 finished;
  logic [1:0]           status_next;
  begin_t               bc;
  begin_t               bc_after;

  function automatic begin_t begin_cmd(input logic [7:0] b, input logic nl_in);
    begin_t r;
    r.phase = PH_CMD;
    r.nl    = nl_in;
    r.err   = 1'b0;
    r.fresh = 1'b0;
    if (b == CHR_NEWLINE && !nl_in) begin
      r.nl = 1'b1;
    end else if (b == CHR_ADD) begin
      r.phase = PH_ADD_LEN;
      r.fresh = 1'b1;
    end else if (b == CHR_COPY) begin
      r.phase = PH_COPY_LEN;
      r.fresh = 1'b1;
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign is_digit = (data_byte >= CHR_ZERO) && (data_byte <= CHR_NINE);
  assign len_val  = LEN_WIDE'(len_acc) * LEN_WIDE'(10) + LEN_WIDE'(data_byte[3:0]);
  assign off_val  = OFF_WIDE'(off_acc) * OFF_WIDE'(10) + OFF_WIDE'(data_byte[3:0]);
  assign used     = (SUM_BITS'(ref_length) > SUM_BITS'(REF_DEPTH)) ?
                    SUM_BITS'(REF_DEPTH) : SUM_BITS'(ref_length);
  assign copy_end = SUM_BITS'(off_acc) + SUM_BITS'(len_acc[COPY_LEN_BITS-1:0]);
  assign copy_bad = (len_acc > LEN_BITS'(MAX_COPY)) || (copy_end > used);
  assign bc       = begin_cmd(data_byte, nl);
  assign bc_after = begin_cmd(data_byte, 1'b0);

  always_comb begin
    phase_next   = phase;
    len_next     = len_acc;
    off_next     = off_acc;
    seen_next    = seen;
    add_rem_next = add_rem;
    nl_next      = nl;
    err_next     = err;
    copy_go      = 1'b0;
    emit_add     = 1'b0;
    finished     = 1'b0;
    ctl.push     = 1'b0;
    ctl.full     = q_full;
    cmd.kind     = CMD_EMIT;
    cmd.addr     = ref_addr;
    cmd.data     = '0;
    cmd.valid    = 1'b0;
    cmd.status   = STATUS_BUSY;
    cmd.len      = '0;
    status_next  = STATUS_BUSY;

    if (accept && mode == MODE_DELTA && !err) begin
      unique case (phase)
        PH_CMD: begin
          phase_next = bc.phase;
          nl_next    = bc.nl;
          err_next   = bc.err;
          if (bc.fresh) begin
            len_next  = '0;
            seen_next = 1'b0;
          end
        end
        PH_ADD_LEN, PH_COPY_LEN: begin
          if (is_digit) begin
            if (len_val[LEN_WIDE-1:LEN_BITS] != '0) begin
              err_next = 1'b1;
            end else begin
              len_next = len_val[LEN_BITS-1:0];
            end
            seen_next = 1'b1;
          end else if (phase == PH_ADD_LEN) begin
            if (!seen || data_byte != CHR_COLON) begin
              err_next = 1'b1;
            end else if (len_acc == '0) begin
              phase_next = PH_CMD;
              nl_next    = 1'b0;
            end else begin
              add_rem_next = len_acc;
              phase_next   = PH_ADD_DATA;
            end
          end else begin
            if (!seen || data_byte != CHR_COMMA) begin
              err_next = 1'b1;
            end else begin
              phase_next = PH_COPY_OFF;
              off_next   = '0;
              seen_next  = 1'b0;
            end
          end
        end
        PH_ADD_DATA: begin
          emit_add     = 1'b1;
          add_rem_next = add_rem - 1'b1;
          if (add_rem == LEN_BITS'(1)) begin
            phase_next = PH_CMD;
            nl_next    = 1'b0;
          end
        end
        PH_COPY_OFF: begin
          if (is_digit) begin
            if (off_val > OFF_WIDE'(REF_DEPTH)) begin
              err_next = 1'b1;
            end else begin
              off_next = off_val[OFF_BITS-1:0];
            end
            seen_next = 1'b1;
          end else if (!seen || copy_bad) begin
            err_next = 1'b1;
          end else begin
            copy_go    = 1'b1;
            phase_next = bc_after.phase;
            nl_next    = bc_after.nl;
            err_next   = bc_after.err;
            if (bc_after.fresh) begin
              len_next  = '0;
              seen_next = 1'b0;
            end
          end
        end
        default: begin
          phase_next = PH_CMD;
        end
      endcase
    end else if (accept && mode == MODE_END && !err) begin
      if (phase == PH_COPY_OFF && seen) begin
        if (copy_bad) begin
          err_next = 1'b1;
        end else begin
          copy_go = 1'b1;
        end
      end else if (phase != PH_CMD) begin
        err_next = 1'b1;
      end
      if (!err_next) begin
        phase_next = PH_CMD;
        nl_next    = 1'b0;
        finished   = 1'b1;
      end
    end

    if (err_next) begin
      status_next = STATUS_ERROR;
    end else if (finished) begin
      status_next = STATUS_DONE;
    end

    if (accept && mode == MODE_LOAD) begin
      ctl.push = 1'b1;
      cmd.kind = CMD_WRITE;
      cmd.data = data_byte;
    end else if (accept && (mode == MODE_DELTA || mode == MODE_END)) begin
      ctl.push   = 1'b1;
      cmd.status = status_next;
      if (copy_go && len_acc != '0) begin
        cmd.kind = CMD_COPY;
        cmd.addr = off_acc[ADDR_BITS-1:0];
        cmd.len  = len_acc[COPY_LEN_BITS-1:0];
      end else if (emit_add) begin
        cmd.data  = data_byte;
        cmd.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CMD;
      len_acc    <= '0;
      off_acc    <= '0;
      seen       <= 1'b0;
      add_rem    <= '0;
      nl         <= 1'b0;
      err        <= 1'b0;
      ref_length <= '0;
    end else begin
      phase   <= phase_next;
      len_acc <= len_next;
      off_acc <= off_next;
      seen    <= seen_next;
      add_rem <= add_rem_next;
      nl      <= nl_next;
      err     <= err_next;
      if (cfg_we) begin
        ref_length <= cfg_data;
      end
    end
  end

endmodule

FILE: rtl/cadd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadd_back
// Output sequencer: owns the reference store, carries out queued requests.
// ----------------------------------------------------------------------------
module cadd_back import cadd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic [1:0] status,
  output logic       last
);

  logic [7:0]               store [REF_DEPTH];
  logic [7:0]               rdata;
  back_state_t              state;
  back_state_t              state_next;
  logic [ADDR_BITS-1:0]     copy_addr;
  logic [ADDR_BITS-1:0]     copy_addr_next;
  logic [COPY_LEN_BITS-1:0] copy_left;
  logic [COPY_LEN_BITS-1:0] copy_left_next;
  logic [1:0]               copy_status;
  logic [1:0]               copy_status_next;
  logic                     out_free;
  logic                     mem_we;
  logic                     load;
  logic [7:0]               load_byte;
  logic                     load_valid;
  logic [1:0]               load_status;
  logic                     load_last;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next       = state;
    copy_addr_next   = copy_addr;
    copy_left_next   = copy_left;
    copy_status_next = copy_status;
    q_pop            = 1'b0;
    mem_we           = 1'b0;
    load             = 1'b0;
    load_byte        = q_cmd.data;
    load_valid       = q_cmd.valid;
    load_status      = q_cmd.status;
    load_last        = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          unique case (q_cmd.kind)
            CMD_WRITE: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            CMD_EMIT: begin
              if (out_free) begin
                q_pop = 1'b1;
                load  = 1'b1;
              end
            end
            CMD_COPY: begin
              q_pop            = 1'b1;
              copy_addr_next   = q_cmd.addr;
              copy_left_next   = q_cmd.len;
              copy_status_next = q_cmd.status;
              state_next       = BK_COPY;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      BK_COPY: begin
        load_byte   = rdata;
        load_valid  = 1'b1;
        load_status = copy_status;
        load_last   = (copy_left == COPY_LEN_BITS'(1));
        if (out_free) begin
          load = 1'b1;
          if (load_last) begin
            state_next = BK_IDLE;
          end else begin
            copy_addr_next = copy_addr + 1'b1;
            copy_left_next = copy_left - 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[q_cmd.addr] <= q_cmd.data;
    end
    rdata <= store[copy_addr_next];
  end

  always_ff @(posedge clk) begin
    copy_addr   <= copy_addr_next;
    copy_left   <= copy_left_next;
    copy_status <= copy_status_next;
    if (load) begin
      out_byte   <= load_byte;
      byte_valid <= load_valid;
      status     <= load_status;
      last       <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/copy_add_delta_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// copy_add_delta_decoder
// Rebuilds a file from a reference store and an ASCII copy/add delta stream.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): mode 0 loads data_byte into the store
// at ref_addr, mode 1 feeds one delta byte, mode 2 marks end of delta, mode 3
// is dropped. Output channel (out_valid / out_stall): one request per rebuilt
// byte, or one byte-less request carrying status when a delta or end item
// emits no byte; last marks the final request of an item. cfg_we / cfg_data
// set ref_length, which the user must write only while the block is idle;
// the block does not enforce this. With the queue empty, an item's first
// request passes through a queue entry and the output register; a copy first
// enters its copy state and reads the store. Throughput: one item per cycle
// into a four-entry queue while in_stall is low; the sequencer drains one
// queued request per cycle unless the output holds it, and a copy keeps it
// busy for up to 64 bytes, one a cycle from the single store read port.
// Reset clears the parser, the error flag, ref_length and the queue; the
// store keeps its contents. While out_stall is high the output request holds,
// the sequencer waits and in_stall rises once the queue fills.
// ----------------------------------------------------------------------------
module copy_add_delta_decoder import cadd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_BITS-1:0]  cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [ADDR_BITS-1:0] ref_addr,
  input  logic [7:0]           data_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 byte_valid,
  output logic [1:0]           status,
  output logic                 last
);

  front_ctl_t ctl;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;

  cadd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .ref_addr  (ref_addr),
    .data_byte (data_byte),
    .ctl       (ctl),
    .q_full    (q_full),
    .cmd       (push_cmd)
  );

  cadd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_ctl (ctl),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  cadd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .status     (status),
    .last       (last)
  );

endmodule

FILE: dv/cadd_rebuild_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cadd_rebuild_check
// Watches both channels and the configuration port of the copy/add delta
// decoder. A parser of its own works out the rebuilt bytes and the status
// that each accepted request should give. Every accepted output request is
// compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module cadd_rebuild_check import cadd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_BITS-1:0]  cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           mode,
  input  logic [ADDR_BITS-1:0] ref_addr,
  input  logic [7:0]           data_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [7:0]           out_byte,
  input  logic                 byte_valid,
  input  logic [1:0]           status,
  input  logic                 last,
  output int                   failures,
  output int                   outstanding
);

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] status;
    logic       last;
  } rebuilt_t;

  logic [7:0]          shadow_store [REF_DEPTH];
  logic [CFG_BITS-1:0] cfg_ref_len;
  phase_t              parse_at;
  int                  len_acc;
  int                  off_acc;
  int                  add_left;
  logic                digit_seen;
  logic                nl_skipped;
  logic                err_latched;
  logic [7:0]          step_bytes [$];
  rebuilt_t            rebuilt_due [$];

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CHR_ZERO && b <= CHR_NINE;
  endfunction

  function automatic void start_command(input logic [7:0] b);
    if (b == CHR_NEWLINE && !nl_skipped) begin
      nl_skipped = 1'b1;
    end else if (b == CHR_ADD) begin
      parse_at = PH_ADD_LEN;
      len_acc = 0;
      digit_seen = 1'b0;
    end else if (b == CHR_COPY) begin
      parse_at = PH_COPY_LEN;
      len_acc = 0;
      digit_seen = 1'b0;
    end else begin
      err_latched = 1'b1;
    end
  endfunction

  function automatic void take_len_digit(input logic [7:0] b);
    int v;
    v = len_acc * 10 + (int'(b) - int'(CHR_ZERO));
    if (v > (1 << LEN_BITS) - 1) err_latched = 1'b1;
    else len_acc = v;
    digit_seen = 1'b1;
  endfunction

  function automatic void run_copy();
    int used;
    used = (int'(cfg_ref_len) < REF_DEPTH) ? int'(cfg_ref_len) : REF_DEPTH;
    if (len_acc > MAX_COPY || off_acc + len_acc > used) begin
      err_latched = 1'b1;
      return;
    end
    for (int i = 0; i < len_acc; i++)
      step_bytes.insert(step_bytes.size(), shadow_store[off_acc + i]);
  endfunction

  function automatic void take_delta(input logic [7:0] b);
    int v;
    case (parse_at)
      PH_CMD: start_command(b);
      PH_ADD_LEN: begin
        if (is_digit(b)) begin
          take_len_digit(b);
        end else if (!digit_seen || b != CHR_COLON) begin
          err_latched = 1'b1;
        end else if (len_acc == 0) begin
          parse_at = PH_CMD;
          nl_skipped = 1'b0;
        end else begin
          add_left = len_acc;
          parse_at = PH_ADD_DATA;
        end
      end
      PH_ADD_DATA: begin
        step_bytes.insert(step_bytes.size(), b);
        add_left--;
        if (add_left == 0) begin
          parse_at = PH_CMD;
          nl_skipped = 1'b0;
        end
      end
      PH_COPY_LEN: begin
        if (is_digit(b)) begin
          take_len_digit(b);
        end else if (!digit_seen || b != CHR_COMMA) begin
          err_latched = 1'b1;
        end else begin
          parse_at = PH_COPY_OFF;
          off_acc = 0;
          digit_seen = 1'b0;
        end
      end
      default: begin
        if (is_digit(b)) begin
          v = off_acc * 10 + (int'(b) - int'(CHR_ZERO));
          if (v > REF_DEPTH) err_latched = 1'b1;
          else off_acc = v;
          digit_seen = 1'b1;
        end else if (!digit_seen) begin
          err_latched = 1'b1;
        end else begin
          run_copy();
          if (!err_latched) begin
            parse_at = PH_CMD;
            nl_skipped = 1'b0;
            start_command(b);
          end
        end
      end
    endcase
  endfunction

  function automatic bit finish_delta();
    if (parse_at == PH_COPY_OFF && digit_seen) run_copy();
    else if (parse_at != PH_CMD) err_latched = 1'b1;
    if (err_latched) return 1'b0;
    parse_at = PH_CMD;
    nl_skipped = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rebuilt_t   e;
    logic [1:0] st;
    bit         done;
    if (rst) begin
      cfg_ref_len = '0;
      parse_at = PH_CMD;
      len_acc = 0;
      off_acc = 0;
      add_left = 0;
      digit_seen = 1'b0;
      nl_skipped = 1'b0;
      err_latched = 1'b0;
      rebuilt_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (rebuilt_due.size() == 0) begin
          $error("unexpected request: out_byte %0h byte_valid %0b status %0d last %0b",
                 out_byte, byte_valid, status, last);
          failures++;
        end else begin
          e = rebuilt_due.pop_front();
          if (out_byte !== e.data) begin
            $error("out_byte: expected %0h, got %0h", e.data, out_byte);
            failures++;
          end
          if (byte_valid !== e.valid) begin
            $error("byte_valid: expected %0b, got %0b", e.valid, byte_valid);
            failures++;
          end
          if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            failures++;
          end
          if (last !== e.last) begin
            $error("last: expected %0b, got %0b", e.last, last);
            failures++;
          end
        end
      end
      if (cfg_we) cfg_ref_len = cfg_data;
      if (in_valid && !in_stall) begin
        if (mode == MODE_LOAD) begin
          shadow_store[ref_addr] = data_byte;
        end else if (mode == MODE_DELTA || mode == MODE_END) begin
          step_bytes.delete();
          done = 1'b0;
          if (!err_latched) begin
            if (mode == MODE_DELTA) take_delta(data_byte);
            else done = finish_delta();
          end
          st = err_latched ? STATUS_ERROR : (done ? STATUS_DONE : STATUS_BUSY);
          if (step_bytes.size() == 0) begin
            e = '{data: 8'h00, valid: 1'b0, status: st, last: 1'b1};
            rebuilt_due.insert(rebuilt_due.size(), e);
          end else begin
            foreach (step_bytes[k]) begin
              e = '{data: step_bytes[k], valid: 1'b1, status: st,
                    last: (k == step_bytes.size() - 1)};
              rebuilt_due.insert(rebuilt_due.size(), e);
            end
          end
        end
      end
    end
    outstanding <= rebuilt_due.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the copy/add delta decoder bench. Fills both ends of the reference
// store, runs a short directed delta and then phases of random well-formed
// deltas under several ref_length settings and idle patterns, and closes with
// one broken sequence followed by noise to exercise the latched error.
// ----------------------------------------------------------------------------
module tb;
  import cadd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         LOAD_SPAN   = MAX_COPY;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           mode = MODE_LOAD;
  logic [ADDR_BITS-1:0] ref_addr = '0;
  logic [7:0]           data_byte = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 byte_valid;
  logic [1:0]           status;
  logic                 last;

  int failures;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int noise_pct = 0;
  int used_len = 0;
  int sent_items = 0;

  copy_add_delta_decoder DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .ref_addr(ref_addr),
    .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .status(status), .last(last)
  );

  cadd_rebuild_check u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode), .ref_addr(ref_addr),
    .data_byte(data_byte), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .status(status), .last(last),
    .failures(failures), .outstanding(outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input logic [1:0] m, input int a, input int d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    ref_addr  <= a[ADDR_BITS-1:0];
    data_byte <= d[7:0];
    do @(posedge clk); while (in_stall);
    if (m != MODE_UNUSED) sent_items++;
  endtask

  task automatic send_delta(input logic [7:0] b);
    if ($urandom_range(99) < noise_pct)
      send_item(MODE_LOAD, $urandom_range(REF_DEPTH - 1), $urandom_range(255));
    if ($urandom_range(199) < noise_pct)
      send_item(MODE_UNUSED, $urandom_range(REF_DEPTH - 1), $urandom_range(255));
    send_item(MODE_DELTA, $urandom_range(REF_DEPTH - 1), b);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_delta(s[i]);
  endtask

  task automatic send_number(input int value);
    string digits;
    digits = $sformatf("%0d", value);
    if ($urandom_range(7) == 0) digits = {"0", digits};
    send_text(digits);
  endtask

  task automatic send_end();
    send_item(MODE_END, $urandom_range(REF_DEPTH - 1), $urandom_range(255));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_ref_length(input int v);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[CFG_BITS-1:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    used_len = (v > REF_DEPTH) ? REF_DEPTH : v;
  endtask

  function automatic logic [7:0] pick_bad_byte();
    logic [7:0] b;
    do b = $urandom_range(255);
    while (b == CHR_ADD || b == CHR_COPY || b == CHR_NEWLINE ||
           (b >= CHR_ZERO && b <= CHR_NINE));
    return b;
  endfunction

  // Keep copies inside the loaded bottom or top window of the store
  task automatic pick_copy(output int n, output int off);
    int base;
    int top;
    int room;
    base = 0;
    top = (used_len < LOAD_SPAN) ? used_len : LOAD_SPAN;
    if (used_len > REF_DEPTH - LOAD_SPAN && $urandom_range(1) == 1) begin
      base = REF_DEPTH - LOAD_SPAN;
      top = used_len;
    end
    room = top - base;
    n = ($urandom_range(5) == 0) ? room : $urandom_range(0, (room < 12) ? room : 12);
    off = ($urandom_range(5) == 0) ? top - n : $urandom_range(base, top - n);
  endtask

  task automatic send_copy(input int n, input int off);
    send_delta(CHR_COPY);
    send_number(n);
    send_delta(CHR_COMMA);
    send_number(off);
  endtask

  task automatic random_command();
    int n;
    int off;
    int pick;
    if ($urandom_range(1)) send_delta(CHR_NEWLINE);
    pick = $urandom_range(99);
    if (pick < 45) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(0, 6);
      send_delta(CHR_ADD);
      send_number(n);
      send_delta(CHR_COLON);
      repeat (n) send_delta($urandom_range(255));
    end else if (pick < 90) begin
      pick_copy(n, off);
      send_copy(n, off);
    end else begin
      send_end();
    end
  endtask

  task automatic broken_tail();
    int n;
    int off;
    case ($urandom_range(11))
      0: send_delta(pick_bad_byte());
      1: send_text("\n\n");
      2: send_text("A:");
      3: send_text("A3,");
      4: send_text("C3,A");
      5: begin
        send_text("A5:");
        send_delta($urandom_range(255));
        send_delta($urandom_range(255));
        send_end();
      end
      6: begin
        send_text("C3,");
        send_end();
      end
      7: send_text("A65536");
      8: send_text("C1,4097");
      9: begin
        send_text("C65,0");
        send_end();
      end
      10: begin
        n = $urandom_range(1, MAX_COPY);
        send_copy(n, (used_len - n + 1 < 0) ? 0 : used_len - n + 1);
        send_end();
      end
      default: begin
        pick_copy(n, off);
        send_copy(n, off);
        send_delta(pick_bad_byte());
      end
    endcase
    repeat (24) send_item($urandom_range(1, 3), $urandom_range(REF_DEPTH - 1),
                          $urandom_range(255));
  endtask

  initial begin
    int  phase_end;
    int  pause_at;
    bit  paused;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int a = 0; a < LOAD_SPAN; a++) begin
      send_item(MODE_LOAD, a, $urandom_range(255));
      send_item(MODE_LOAD, REF_DEPTH - LOAD_SPAN + a, $urandom_range(255));
    end
    set_ref_length((1 << CFG_BITS) - 1);

    send_text("\nA0:A02:");
    send_delta(8'h00);
    send_delta(8'hFF);
    send_text("C64,4032\nC0,4096");
    send_item(MODE_UNUSED, 0, 0);
    send_end();

    noise_pct = 6;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          set_ref_length(REF_DEPTH);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_ref_length($urandom_range(1, REF_DEPTH - 1));
          send_idle_pct = 82;
          stall_pct = 0;
        end
        2: begin
          set_ref_length(0);
          send_idle_pct = 0;
          stall_pct = 82;
        end
        3: begin
          set_ref_length($urandom_range(0, (1 << CFG_BITS) - 1));
          send_idle_pct = 34;
          stall_pct = 34;
        end
        4: begin
          set_ref_length(REF_DEPTH - 1);
          send_idle_pct = 0;
          stall_pct = 0;
        end
        default: begin
          set_ref_length($urandom_range(MAX_COPY, REF_DEPTH));
          send_idle_pct = 34;
          stall_pct = 34;
        end
      endcase
      phase_end = sent_items + 45;
      pause_at = sent_items + $urandom_range(5, 40);
      paused = 1'b0;
      while (sent_items < phase_end) begin
        if (!paused && sent_items >= pause_at) begin
          wait_drained();
          paused = 1'b1;
        end
        random_command();
      end
      send_end();
    end
    broken_tail();

    wait_drained();
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
